// ===== src/moving_average_or_exponential_filter_top_defines.svh =====
// Assertion helpers for the filter top level.
// Both macros sample on clk and are disabled while rst is high.
`ifndef MOVING_AVERAGE_OR_EXPONENTIAL_FILTER_TOP_DEFINES_SVH
`define MOVING_AVERAGE_OR_EXPONENTIAL_FILTER_TOP_DEFINES_SVH

// Same-cycle implication
`define MAEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MAEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/maef_pkg.sv =====
`timescale 1ns / 1ps

package maef_pkg;

  // Default sizes
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register file layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int LEN_CFG_W  = 7;
  localparam int WEIGHT_W   = 17;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd2;

  localparam logic MODE_MOVING_AVG = 1'b0;
  localparam logic MODE_EXP        = 1'b1;

  // Q1.16 weight
  localparam int WFRAC = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } maef_state_t;

  // Delay-line cell controls: shift takes the newer neighbor, rot the older one
  typedef struct packed {
    logic shift;
    logic rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/maef_cell.sv =====
`timescale 1ns / 1ps

module maef_cell import maef_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] shift_d,
  input  logic signed [SAMPLE_BITS-1:0] rot_d,
  output logic signed [SAMPLE_BITS-1:0] q
);

  // One delay-line slot: shift toward older on a new sample, rotate back while summing
  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      q <= shift_d;
    end else if (ctrl.rot) begin
      q <= rot_d;
    end
  end

endmodule

// ===== src/maef_div.sv =====
`timescale 1ns / 1ps

module maef_div import maef_pkg::*; #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] quo_next;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, quo[DVD_W-1]};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    quo_next = {quo[DVD_W-2:0], ge};
  end

  // Control: count DVD_W steps, hold done until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/moving_average_or_exponential_filter_top.sv =====
// Moving-average / exponential-smoothing filter for signed audio samples.
// Input channel: sample_in and first_sample, moved on in_valid with in_stall low.
// first_sample starts a new record; older samples then count as zero.
// Output channel: one sample_out beat per input beat, moved on out_valid with
// out_stall low. A finished result waits in the output register, so the next
// input beat is taken while the previous result is still stalled.
// Configuration: cfg_index / cfg_data written on cfg_valid (cfg_ready is
// always high); write only while the block is idle.
// Steps from input beat to output register:
//   moving average : the delay line of cells is rotated once around to sum
//                    the window, then a bit-serial divider runs one quotient
//                    bit per cycle.
//   exponential    : multiply, add, then load; a record start goes straight to load.
// One item is in flight at a time; the next beat is taken once the result has
// entered the output register and the machine is back in idle.
// Reset clears the record, the previous output and the registers
// (mode 0, window 1, weight 0); the first beat after reset starts a record.
`timescale 1ns / 1ps
`include "moving_average_or_exponential_filter_top_defines.svh"

module moving_average_or_exponential_filter_top import maef_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          first_sample,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W  = $clog2(WINDOW_MAX);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = SAMPLE_BITS + 18;

  maef_state_t state, state_next;

  // configuration registers
  logic                 filter_mode;
  logic [LEN_CFG_W-1:0] window_len;
  logic [WEIGHT_W-1:0]  smoothing_weight;

  // record and datapath registers
  logic [LEN_W-1:0]              fill_cnt;
  logic [LEN_W-1:0]              n_cnt;
  logic [CNT_W-1:0]              k_cnt;
  logic signed [SUM_W-1:0]       acc;
  logic signed [SAMPLE_BITS-1:0] prev_output;
  logic signed [SAMPLE_BITS-1:0] result;
  logic signed [PROD_W-1:0]      p_old;
  logic signed [PROD_W-1:0]      p_new;

  // combinational helpers
  logic                   in_acc;
  logic                   out_free;
  logic [31:0]            len_wide;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       fill_base;
  logic [LEN_W-1:0]       fill_new;
  logic [LEN_W-1:0]       n_new;
  logic                   starting;
  logic [WEIGHT_W-1:0]    w_eff;
  logic [WEIGHT_W-1:0]    w_rest;
  logic signed [17:0]     wa;
  logic signed [17:0]     wb;
  logic signed [PROD_W:0] esum;
  logic [SUM_W-1:0]       acc_mag;
  logic [SUM_W-1:0]       quo;
  logic [SUM_W-1:0]       quo_signed;

  cell_ctrl_t cell_ctrl;
  div_ctrl_t  div_ctrl;
  div_stat_t  div_stat;

  logic signed [SAMPLE_BITS-1:0] cell_q [WINDOW_MAX];

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode      <= MODE_MOVING_AVG;
      window_len       <= LEN_CFG_W'(1);
      smoothing_weight <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILTER_MODE:      filter_mode      <= cfg_data[0];
        REG_WINDOW_LEN:       window_len       <= cfg_data[LEN_CFG_W-1:0];
        REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window: zero reads as one, oversized clamps to the line length
  always_comb begin
    len_wide = 32'(window_len);
    if (len_wide == 32'd0) begin
      len_wide = 32'd1;
    end else if (len_wide > 32'(WINDOW_MAX)) begin
      len_wide = 32'(WINDOW_MAX);
    end
    len_eff = LEN_W'(len_wide);
  end

  // Record bookkeeping for the beat being taken
  always_comb begin
    fill_base = first_sample ? '0 : fill_cnt;
    starting  = (fill_base == '0);
    fill_new  = (fill_base == LEN_W'(WINDOW_MAX)) ? fill_base : fill_base + 1'b1;
    n_new     = (fill_new < len_eff) ? fill_new : len_eff;
  end

  // Weight saturates at 1.0
  always_comb begin
    w_eff  = (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
    w_rest = WEIGHT_ONE - w_eff;
    wa     = $signed({1'b0, w_rest});
    wb     = $signed({1'b0, w_eff});
    esum   = (PROD_W + 1)'(p_old) + (PROD_W + 1)'(p_new);
  end

  // Divider operands and signed quotient (truncation toward zero)
  always_comb begin
    acc_mag    = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
    quo_signed = acc[SUM_W-1] ? SUM_W'(-quo) : quo;
  end

  // Delay line: row of cells, newest sample in cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : gen_cell
    logic signed [SAMPLE_BITS-1:0] shift_d;
    logic signed [SAMPLE_BITS-1:0] rot_d;

    if (i == 0) begin : gen_head
      assign shift_d = sample_in;
    end else begin : gen_body
      assign shift_d = cell_q[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : gen_tail
      assign rot_d = cell_q[0];
    end else begin : gen_mid
      assign rot_d = cell_q[i+1];
    end

    maef_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk    (clk),
      .ctrl   (cell_ctrl),
      .shift_d(shift_d),
      .rot_d  (rot_d),
      .q      (cell_q[i])
    );
  end

  maef_div #(
    .DVD_W(SUM_W),
    .DVS_W(LEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (div_ctrl),
    .dividend(acc_mag),
    .divisor (len_eff),
    .quotient(quo),
    .stat    (div_stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (filter_mode == MODE_EXP) begin
            state_next = starting ? ST_DONE : ST_MUL;
          end else begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (k_cnt == CNT_W'(WINDOW_MAX - 1)) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall        = (state != ST_IDLE);
    cell_ctrl.shift = in_acc;
    cell_ctrl.rot   = (state == ST_SUM);
    div_ctrl.start  = (state == ST_DIV_GO);
  end

  // State and record control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_cnt    <= '0;
      n_cnt       <= '0;
      k_cnt       <= '0;
      prev_output <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill_cnt <= fill_new;
        n_cnt    <= n_new;
        k_cnt    <= '0;
      end else if (state == ST_SUM) begin
        k_cnt <= k_cnt + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        prev_output <= result;
      end
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc    <= '0;
      result <= sample_in;
    end else begin
      unique case (state)
        ST_SUM: begin
          if (LEN_W'(k_cnt) < n_cnt) begin
            acc <= acc + SUM_W'(cell_q[0]);
          end
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            result <= quo_signed[SAMPLE_BITS-1:0];
          end
        end
        ST_MUL: begin
          p_old <= PROD_W'(wa) * PROD_W'(prev_output);
          p_new <= PROD_W'(wb) * PROD_W'(cell_q[0]);
        end
        ST_ADD: begin
          result <= esum[WFRAC +: SAMPLE_BITS];
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      sample_out <= result;
    end
  end

  // Checks
  `MAEF_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "beat taken while busy")
  `MAEF_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE, "result without finish")
  `MAEF_ASSERT_NOW(a_sum_count, state == ST_SUM, (n_cnt != '0) && (n_cnt <= len_eff), "bad window count")

endmodule

// ===== test/tb_moving_average_or_exponential_filter_top.sv =====
`timescale 1ns / 1ps

module tb_moving_average_or_exponential_filter_top;
  import maef_pkg::*;

  localparam int WIN_MAX      = WINDOW_MAX_DEF;
  localparam int RAND_ITEMS   = 850;
  localparam int CALM_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 120;

  // index past the end of the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [15:0] RAIL_VALS [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [15:0]    smp;
    logic                  first;
    logic                  known;
    logic signed [15:0]    want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    sample_in = 16'sd0;
  logic                  first_sample = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    sample_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed-in expectation that travels with the beat on the input side
  logic                  row_known = 1'b0;
  logic signed [15:0]    row_value = 16'sd0;

  // predictor state and register copy
  logic signed [15:0]    dl_mem [WIN_MAX];
  int unsigned           dl_wr;
  int unsigned           dl_fill;
  logic signed [15:0]    last_out;
  logic                  cur_mode;
  int unsigned           cur_win;
  int unsigned           cur_weight;

  logic signed [15:0]    out_samples_due [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    stall_left = 0;
  logic                  src_idle = 1'b0;
  logic                  sink_idle = 1'b0;

  moving_average_or_exponential_filter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .first_sample (first_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // filter behavior: one output sample per input sample
  function automatic logic signed [15:0] filter_predict(input logic signed [15:0] x,
                                                        input logic first);
    int unsigned win;
    int unsigned n;
    int unsigned w;
    int unsigned k;
    longint      acc;
    logic        starting;
    if (first) begin
      dl_wr   = 0;
      dl_fill = 0;
    end
    starting = (dl_fill == 0);
    dl_mem[dl_wr] = x;
    dl_wr = (dl_wr + 1) % WIN_MAX;
    if (dl_fill < WIN_MAX) dl_fill++;
    if (cur_mode == MODE_MOVING_AVG) begin
      win = (cur_win == 0) ? 1 : cur_win;
      if (win > WIN_MAX) win = WIN_MAX;
      n = (dl_fill < win) ? dl_fill : win;
      acc = 0;
      for (k = 0; k < n; k++) acc += dl_mem[(dl_wr + WIN_MAX - 1 - k) % WIN_MAX];
      // signed divide truncates toward zero
      acc = acc / longint'(win);
    end else begin
      w = (cur_weight > int'(WEIGHT_ONE)) ? int'(WEIGHT_ONE) : cur_weight;
      if (starting) acc = longint'(x);
      else acc = (longint'(int'(WEIGHT_ONE) - w) * longint'(last_out)
                  + longint'(w) * longint'(x)) >>> WFRAC;
    end
    last_out = acc[15:0];
    return acc[15:0];
  endfunction

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (sink_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
    out_stall <= (stall_left != 0);
  end

  // beat monitor: register copy, prediction, result check
  always @(posedge clk) begin
    logic signed [15:0] want;
    logic signed [15:0] calc;
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (out_samples_due.size() == 0) begin
          note_mismatch($sformatf("sample_out %0d with nothing expected", sample_out));
        end else begin
          want = out_samples_due.pop_front();
          if (sample_out !== want)
            note_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want));
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_FILTER_MODE:      cur_mode = cfg_data[0];
          REG_WINDOW_LEN:       cur_win = cfg_data[LEN_CFG_W-1:0];
          REG_SMOOTHING_WEIGHT: cur_weight = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_stall === 1'b0) begin
        calc = filter_predict(sample_in, first_sample);
        out_samples_due.push_back(row_known ? row_value : calc);
      end
    end
  end

  task automatic push_beat(input logic signed [15:0] s, input logic f,
                           input logic known, input logic signed [15:0] kv);
    int gap;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    sample_in    <= s;
    first_sample <= f;
    row_known    <= known;
    row_value    <= kv;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // hold off input until every result is back and the block sits idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (out_samples_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{1'b1, idx, data, 16'sd0, 1'b0, 1'b0, 16'sd0};
    return r;
  endfunction

  function automatic dir_row_t smp_row(input logic signed [15:0] s, input logic f,
                                       input logic known, input logic signed [15:0] want);
    dir_row_t r;
    r = '{1'b0, REG_FILTER_MODE, '0, s, f, known, want};
    return r;
  endfunction

  initial begin
    dir_row_t           plan [$];
    int                 sent;
    int                 n;
    int                 j;
    int                 r;
    int                 wl;
    int unsigned        wt;
    logic               calm;
    logic               f;
    logic signed [15:0] s;

    // predictor reset state
    foreach (dl_mem[i]) dl_mem[i] = 16'sd0;
    dl_wr      = 0;
    dl_fill    = 0;
    last_out   = 16'sd0;
    cur_mode   = MODE_MOVING_AVG;
    cur_win    = 1;
    cur_weight = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: moving average over one sample, first beat starts a record
    plan.push_back(smp_row(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF));
    plan.push_back(smp_row(16'sh8000, 1'b0, 1'b1, 16'sh8000));
    plan.push_back(smp_row(16'sd0, 1'b0, 1'b1, 16'sd0));
    plan.push_back(smp_row(-16'sd1, 1'b1, 1'b1, -16'sd1));
    // widest window, sum of -1 truncates to zero
    plan.push_back(cfg_row(REG_WINDOW_LEN, 17'd64));
    plan.push_back(smp_row(16'sh7FFF, 1'b1, 1'b1, 16'sd511));
    plan.push_back(smp_row(16'sh8000, 1'b0, 1'b1, 16'sd0));
    plan.push_back(smp_row(16'sd12345, 1'b0, 1'b0, 16'sd0));
    // zero window acts as one
    plan.push_back(cfg_row(REG_WINDOW_LEN, 17'd0));
    plan.push_back(smp_row(16'sd1234, 1'b0, 1'b1, 16'sd1234));
    // oversized window clamps to the maximum, all data bits high
    plan.push_back(cfg_row(REG_WINDOW_LEN, 17'h1FFFF));
    plan.push_back(smp_row(16'sh8000, 1'b1, 1'b1, -16'sd512));
    plan.push_back(smp_row(16'sh8000, 1'b0, 1'b1, -16'sd1024));
    // exponential, zero weight: record start passes, then output holds
    plan.push_back(cfg_row(REG_FILTER_MODE, 17'd1));
    plan.push_back(cfg_row(REG_SMOOTHING_WEIGHT, 17'd0));
    plan.push_back(smp_row(16'sd1000, 1'b1, 1'b1, 16'sd1000));
    plan.push_back(smp_row(-16'sd5, 1'b0, 1'b1, 16'sd1000));
    // oversized weight clamps to one: output follows input
    plan.push_back(cfg_row(REG_SMOOTHING_WEIGHT, 17'h1FFFF));
    plan.push_back(smp_row(16'sh8000, 1'b0, 1'b1, 16'sh8000));
    plan.push_back(smp_row(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF));
    plan.push_back(cfg_row(REG_SMOOTHING_WEIGHT, 17'd32768));
    plan.push_back(smp_row(16'sd100, 1'b0, 1'b0, 16'sd0));
    plan.push_back(smp_row(16'sh8000, 1'b0, 1'b0, 16'sd0));
    // write past the register list is dropped
    plan.push_back(cfg_row(REG_UNUSED, 17'h1FFFF));
    plan.push_back(smp_row(-16'sd200, 1'b1, 1'b1, -16'sd200));
    plan.push_back(smp_row(16'sd0, 1'b0, 1'b0, 16'sd0));
    // mode switches inside a record carry the history and last output along
    plan.push_back(cfg_row(REG_FILTER_MODE, 17'd0));
    plan.push_back(cfg_row(REG_WINDOW_LEN, 17'd4));
    plan.push_back(smp_row(16'sd7, 1'b0, 1'b0, 16'sd0));
    plan.push_back(smp_row(-16'sd9, 1'b0, 1'b0, 16'sd0));
    plan.push_back(cfg_row(REG_FILTER_MODE, 17'd1));
    plan.push_back(smp_row(16'sd300, 1'b0, 1'b0, 16'sd0));

    src_idle  = 1'b1;
    sink_idle = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_beat(plan[i].smp, plan[i].first, plan[i].known, plan[i].want);
      end
    end

    // random phases, each with its own register setting
    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      calm      = (sent >= RAND_ITEMS - CALM_ITEMS);
      src_idle  = !calm && ($urandom_range(0, 3) != 0);
      sink_idle = !calm && ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 1) == 0)
        write_reg(REG_FILTER_MODE,
                  {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
                   1'($urandom_range(0, 1))});
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0: wl = 0;
          1: wl = 1;
          2: wl = WIN_MAX;
          3: wl = 127;
          4, 5: wl = $urandom_range(1, 8);
          default: wl = $urandom_range(0, 127);
        endcase
        write_reg(REG_WINDOW_LEN,
                  {($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0, 7'(wl)});
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0: wt = 0;
          1: wt = 1;
          2: wt = 65535;
          3: wt = 65536;
          4: wt = 17'h1FFFF;
          5: wt = 17'($urandom);
          default: wt = $urandom_range(0, 65536);
        endcase
        write_reg(REG_SMOOTHING_WEIGHT, 17'(wt));
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 17'($urandom));

      n = $urandom_range(20, 60);
      for (j = 0; j < n && sent < RAND_ITEMS; j++) begin
        f = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
        r = $urandom_range(0, 7);
        if (r == 0) s = RAIL_VALS[$urandom_range(0, 3)];
        else if (r < 3) s = $signed(16'($urandom_range(0, 200))) - 16'sd100;
        else s = 16'($urandom);
        // occasional full drain in the middle of a record
        if ($urandom_range(0, 59) == 0) settle();
        push_beat(s, f, 1'b0, 16'sd0);
        sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && out_samples_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
